[hw/rtl/cng_pkg.sv]
// ----------------------------------------------------------------------------
// Numbers-game engine package
// Shared widths, command kinds, Coxeter code decoding and the queue entry type.
// ----------------------------------------------------------------------------
package cng_pkg;

    localparam int NUM_ROWS       = 8;
    localparam int CODE_BITS      = 3;
    localparam int ROW_BITS       = NUM_ROWS * CODE_BITS;
    localparam int CFG_INDEX_BITS = $clog2(NUM_ROWS);
    localparam int GEN_BITS       = 3;
    localparam int LEN_BITS       = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic CMD_MULTIPLY = 1'b0;
    localparam logic CMD_REDUCE   = 1'b1;

    localparam logic [1:0] KIND_MULTIPLY = 2'd0;
    localparam logic [1:0] KIND_SKIP     = 2'd1;
    localparam logic [1:0] KIND_REDUCE   = 2'd2;

    localparam logic [CODE_BITS-1:0] CODE_NONE = 3'd0;
    localparam logic [CODE_BITS-1:0] CODE_M2   = 3'd1;
    localparam logic [CODE_BITS-1:0] CODE_M3   = 3'd2;
    localparam logic [CODE_BITS-1:0] CODE_M4   = 3'd3;
    localparam logic [CODE_BITS-1:0] CODE_M6   = 3'd4;
    localparam logic [CODE_BITS-1:0] CODE_INF  = 3'd5;

    typedef struct packed {
        logic [1:0]          kind;
        logic [GEN_BITS-1:0] generator;
    } t_cmd;

    typedef struct packed {
        logic       unsup;
        logic [1:0] factor;
    } t_coef;

    function automatic t_coef code_coef(input logic [CODE_BITS-1:0] code);
        t_coef c;
        c.unsup  = 1'b0;
        c.factor = 2'd0;
        case (code)
            CODE_NONE, CODE_M2: c.factor = 2'd0;
            CODE_M3:            c.factor = 2'd1;
            CODE_M4:            c.factor = 2'd2;
            CODE_M6:            c.factor = 2'd3;
            CODE_INF:           c.factor = 2'd2;
            default:            c.unsup  = 1'b1;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/cng_cmd_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command item to the engine.
// ----------------------------------------------------------------------------
interface cng_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [cng_pkg::GEN_BITS-1:0]  generator;

    modport source (output valid, output command, output generator, input ready);
    modport sink   (input valid, input command, input generator, output ready);
endinterface

[hw/rtl/cng_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item from the engine.
// ----------------------------------------------------------------------------
interface cng_res_if;
    logic                          valid;
    logic                          ready;
    logic [cng_pkg::GEN_BITS-1:0]  generator_out;
    logic [cng_pkg::LEN_BITS-1:0]  word_length;
    logic                          is_last;
    logic                          is_empty;
    logic                          unsupported_code;
    logic                          overflowed;

    modport source (output valid, output generator_out, output word_length,
                    output is_last, output is_empty, output unsupported_code,
                    output overflowed, input ready);
    modport sink   (input valid, input generator_out, input word_length,
                    input is_last, input is_empty, input unsupported_code,
                    input overflowed, output ready);
endinterface

[hw/rtl/cng_front.sv]
// ----------------------------------------------------------------------------
// Numbers-game front end
// Accepts command items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module cng_front #(
    parameter int RANK = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cng_cmd_if.sink       i_cmd,
    input  logic          i_pop,
    output logic          o_cmd_valid,
    output cng_pkg::t_cmd o_cmd
);
    import cng_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_cmd                r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                push;
    t_cmd                entry;

    always_comb begin
        entry.generator = i_cmd.generator;
        if (i_cmd.command == CMD_REDUCE) begin
            entry.kind = KIND_REDUCE;
        end else if ({1'b0, i_cmd.generator} < (GEN_BITS + 1)'(RANK)) begin
            entry.kind = KIND_MULTIPLY;
        end else begin
            entry.kind = KIND_SKIP;
        end
    end

    assign i_cmd.ready = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= entry;
        end
    end

endmodule

[hw/rtl/cng_back.sv]
// ----------------------------------------------------------------------------
// Numbers-game back end
// Holds the Coxeter matrix, root values and length, and carries out multiply
// and reduce commands through a diagonal step and a parallel update step.
// ----------------------------------------------------------------------------
module cng_back #(
    parameter int RANK       = 8,
    parameter int VALUE_BITS = 16,
    parameter int MAX_LEN    = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cng_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [cng_pkg::ROW_BITS-1:0]        i_cfg_data,
    input  logic                                i_cmd_valid,
    input  cng_pkg::t_cmd                       i_cmd,
    output logic                                o_pop,
    cng_res_if.source                           o_res
);
    import cng_pkg::*;

    localparam int SEL_BITS = $clog2(RANK);
    localparam int EXT      = VALUE_BITS + 3;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DIAG   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam logic signed [EXT-1:0] VMAX = EXT'((longint'(1) <<< (VALUE_BITS - 1)) - 1);
    localparam logic signed [EXT-1:0] VMIN = -VMAX - EXT'(1);

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef t_value t_vec [RANK];

    typedef struct packed {
        logic [GEN_BITS-1:0] gen;
        logic [LEN_BITS-1:0] len;
        logic                last;
        logic                empty;
        logic                unsup;
        logic                ovf;
    } t_result;

    function automatic logic [VALUE_BITS:0] saturate(input logic signed [EXT-1:0] x);
        if (x > VMAX) begin
            return {1'b1, VMAX[VALUE_BITS-1:0]};
        end else if (x < VMIN) begin
            return {1'b1, VMIN[VALUE_BITS-1:0]};
        end
        return {1'b0, x[VALUE_BITS-1:0]};
    endfunction

    function automatic logic [VALUE_BITS:0] add_scaled(input t_value v, input t_value s,
                                                       input logic [1:0] factor);
        logic signed [EXT-1:0] a;
        logic signed [EXT-1:0] b;
        logic signed [EXT-1:0] sum;
        a = EXT'(v);
        b = EXT'(s);
        case (factor)
            2'd0:    sum = a;
            2'd1:    sum = a + b;
            2'd2:    sum = a + (b <<< 1);
            default: sum = a + b + (b <<< 1);
        endcase
        return saturate(sum);
    endfunction

    function automatic logic [SEL_BITS:0] lowest_neg(input t_vec v);
        logic [SEL_BITS:0] res;
        res = '0;
        for (int i = RANK - 1; i >= 0; i--) begin
            if (v[i][VALUE_BITS-1]) begin
                res = {1'b1, SEL_BITS'(i)};
            end
        end
        return res;
    endfunction

    function automatic t_result make_result(input logic [GEN_BITS-1:0] gen,
                                            input logic [LEN_BITS-1:0] len,
                                            input logic last, input logic empty,
                                            input logic unsup, input logic ovf);
        t_result r;
        r.gen   = gen;
        r.len   = len;
        r.last  = last;
        r.empty = empty;
        r.unsup = unsup;
        r.ovf   = ovf;
        return r;
    endfunction

    logic [1:0]          r_state, n_state;
    logic [ROW_BITS-1:0] r_matrix [NUM_ROWS];
    logic [ROW_BITS-1:0] n_matrix [NUM_ROWS];
    t_vec                r_root, n_root;
    t_vec                r_work, n_work;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic [GEN_BITS-1:0] r_gen, n_gen;
    logic                r_reduce, n_reduce;
    t_value              r_vs_old, n_vs_old;
    t_value              r_diag, n_diag;
    logic                r_unsup, n_unsup;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    t_vec                vec;
    logic [ROW_BITS-1:0] row;
    logic [SEL_BITS-1:0] sel;
    t_value              vs;
    t_coef               diag_coef;
    logic [VALUE_BITS:0] diag_sum;
    logic [SEL_BITS:0]   root_neg;
    logic [SEL_BITS:0]   work_neg;
    logic                out_free;
    logic [LEN_BITS-1:0] count_next;
    logic                at_limit;
    logic                emit_last;
    logic                emit_ovf;
    logic                upd_unsup;
    logic                upd_ovf;
    logic                len_ovf;

    t_coef               lane_coef  [RANK];
    t_value              lane_src   [RANK];
    logic [VALUE_BITS:0] lane_sum   [RANK];
    logic [VALUE_BITS:0] lane_neg   [RANK];
    t_value              lane_val   [RANK];
    logic                lane_unsup [RANK];
    logic                lane_ovf   [RANK];

    assign row       = r_matrix[r_gen];
    assign sel       = r_gen[SEL_BITS-1:0];
    assign vs        = vec[sel];
    assign diag_coef = code_coef(row[CODE_BITS * sel +: CODE_BITS]);
    assign diag_sum  = add_scaled(vs, vs, diag_coef.factor);
    assign root_neg  = lowest_neg(r_root);
    assign work_neg  = lowest_neg(r_work);
    assign out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        for (int i = 0; i < RANK; i++) begin
            vec[i] = r_reduce ? r_work[i] : r_root[i];
        end
    end

    for (genvar gi = 0; gi < RANK; gi++) begin : g_lane
        always_comb begin
            lane_coef[gi]  = code_coef(row[CODE_BITS * gi +: CODE_BITS]);
            lane_src[gi]   = (SEL_BITS'(gi) < sel) ? r_vs_old : r_diag;
            lane_sum[gi]   = add_scaled(vec[gi], lane_src[gi], lane_coef[gi].factor);
            lane_neg[gi]   = saturate(-EXT'(r_diag));
            lane_unsup[gi] = 1'b0;
            if (SEL_BITS'(gi) == sel) begin
                lane_val[gi] = lane_neg[gi][VALUE_BITS-1:0];
                lane_ovf[gi] = lane_neg[gi][VALUE_BITS];
            end else if (lane_coef[gi].unsup) begin
                lane_val[gi]   = '0;
                lane_ovf[gi]   = 1'b0;
                lane_unsup[gi] = 1'b1;
            end else begin
                lane_val[gi] = lane_sum[gi][VALUE_BITS-1:0];
                lane_ovf[gi] = lane_sum[gi][VALUE_BITS];
            end
        end
    end

    always_comb begin
        upd_unsup = 1'b0;
        upd_ovf   = 1'b0;
        for (int i = 0; i < RANK; i++) begin
            upd_unsup = upd_unsup | lane_unsup[i];
            upd_ovf   = upd_ovf | lane_ovf[i];
        end
    end

    assign count_next = r_count + 1'b1;
    assign at_limit   = (count_next >= LEN_BITS'(MAX_LEN));
    assign emit_last  = !work_neg[SEL_BITS] || at_limit;
    assign emit_ovf   = r_ovf || (work_neg[SEL_BITS] && at_limit);

    always_comb begin
        n_state     = r_state;
        n_matrix    = r_matrix;
        n_root      = r_root;
        n_work      = r_work;
        n_len       = r_len;
        n_count     = r_count;
        n_gen       = r_gen;
        n_reduce    = r_reduce;
        n_vs_old    = r_vs_old;
        n_diag      = r_diag;
        n_unsup     = r_unsup;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        len_ovf     = 1'b0;

        if (i_cfg_we) begin
            n_matrix[i_cfg_index] = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop   = 1'b1;
                    n_gen   = i_cmd.generator;
                    n_unsup = 1'b0;
                    n_ovf   = 1'b0;
                    n_count = '0;
                    case (i_cmd.kind)
                        KIND_MULTIPLY: begin
                            n_reduce = 1'b0;
                            n_state  = S_DIAG;
                        end
                        KIND_REDUCE: begin
                            n_reduce = 1'b1;
                            n_work   = r_root;
                            if (root_neg[SEL_BITS]) begin
                                n_gen   = GEN_BITS'(root_neg[SEL_BITS-1:0]);
                                n_state = S_DIAG;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out = make_result('0, '0, 1'b1, 1'b1, 1'b0, 1'b0);
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out = make_result('0, r_len, 1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    endcase
                end
            end
            S_DIAG: begin
                n_vs_old = vs;
                if (diag_coef.unsup) begin
                    n_diag  = '0;
                    n_unsup = 1'b1;
                end else begin
                    n_diag = diag_sum[VALUE_BITS-1:0];
                    n_ovf  = r_ovf | diag_sum[VALUE_BITS];
                end
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                for (int i = 0; i < RANK; i++) begin
                    if (r_reduce) begin
                        n_work[i] = lane_val[i];
                    end else begin
                        n_root[i] = lane_val[i];
                    end
                end
                if (!r_reduce) begin
                    if (r_diag > 0) begin
                        if (r_len >= LEN_BITS'(MAX_LEN)) begin
                            n_len   = LEN_BITS'(MAX_LEN);
                            len_ovf = 1'b1;
                        end else begin
                            n_len = r_len + 1'b1;
                        end
                    end else begin
                        if (r_len == '0) begin
                            len_ovf = 1'b1;
                        end else begin
                            n_len = r_len - 1'b1;
                        end
                    end
                end
                n_unsup = r_unsup | upd_unsup;
                n_ovf   = r_ovf | upd_ovf | len_ovf;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!r_reduce) begin
                        n_out   = make_result('0, r_len, 1'b1, 1'b0, r_unsup, r_ovf);
                        n_state = S_IDLE;
                    end else begin
                        n_out   = make_result(r_gen, count_next, emit_last, 1'b0,
                                              r_unsup, emit_ovf);
                        n_ovf   = emit_ovf;
                        n_count = count_next;
                        if (emit_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_gen   = GEN_BITS'(work_neg[SEL_BITS-1:0]);
                            n_state = S_DIAG;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            for (int i = 0; i < NUM_ROWS; i++) begin
                r_matrix[i] <= '0;
            end
            for (int i = 0; i < RANK; i++) begin
                r_root[i] <= t_value'(1);
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
            r_matrix    <= n_matrix;
            r_root      <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work   <= n_work;
        r_count  <= n_count;
        r_gen    <= n_gen;
        r_reduce <= n_reduce;
        r_vs_old <= n_vs_old;
        r_diag   <= n_diag;
        r_unsup  <= n_unsup;
        r_ovf    <= n_ovf;
        r_out    <= n_out;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.generator_out    = r_out.gen;
    assign o_res.word_length      = r_out.len;
    assign o_res.is_last          = r_out.last;
    assign o_res.is_empty         = r_out.empty;
    assign o_res.unsupported_code = r_out.unsup;
    assign o_res.overflowed       = r_out.ovf;

endmodule

[hw/rtl/coxeter_numbers_game_engine.sv]
// ----------------------------------------------------------------------------
// Coxeter numbers-game engine
// Command items enter on i_cmd; result items leave on o_res. Both channels
// are valid/ready and an item moves at a clock edge where both are high.
// The user must write the eight matrix rows through i_cfg_we, i_cfg_index
// and i_cfg_data only while the engine is idle; the block does not enforce it.
// A two-entry queue sits between the front end and the execution back end,
// so commands keep being accepted while a result waits in the output register.
// A multiply passes through the back end as a dequeue, a diagonal step, a
// parallel update and a result step. A multiply by an out-of-range generator
// and a reduce with no negative entry give their result at the dequeue step.
// A reduce takes a dequeue step, then a diagonal step, a parallel update and
// a result step for each emitted generator.
// When the receiver holds o_res.ready low the back end waits with its next
// result, the queue fills, and then i_cmd.ready falls.
// Synchronous reset clears the queue and output register, sets every root
// value to one, the length to zero and all matrix rows to zero.
// ----------------------------------------------------------------------------
module coxeter_numbers_game_engine #(
    parameter int RANK       = 8,
    parameter int VALUE_BITS = 16,
    parameter int MAX_LEN    = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cng_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [cng_pkg::ROW_BITS-1:0]        i_cfg_data,
    cng_cmd_if.sink                             i_cmd,
    cng_res_if.source                           o_res
);
    import cng_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic pop;

    cng_front #(
        .RANK (RANK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_pop       (pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    cng_back #(
        .RANK       (RANK),
        .VALUE_BITS (VALUE_BITS),
        .MAX_LEN    (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_res       (o_res)
    );

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("Result valid right after reset.");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.is_empty |->
            o_res.is_last && (o_res.word_length == '0) && (o_res.generator_out == '0))
        else $error("Empty reduce result is malformed.");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.word_length <= LEN_BITS'(MAX_LEN)))
        else $error("Word length exceeds the maximum.");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid)
        else $error("Back end took a command from an empty queue.");

endmodule
